[rtl/mdsu_pkg.sv]
// Shared widths, register codes and control types for the diffusion stencil update.
// Used by mdsu_axis and masked_diffusion_stencil_update.
// No dependencies.
package mdsu_pkg;

   localparam int DATA_W  = 32;            // Q16.16 value
   localparam int FRAC_W  = 16;            // fractional bits
   localparam int HALF_W  = DATA_W / 2;    // coefficient half width
   localparam int DIFF_W  = DATA_W + 1;    // one-sided difference
   localparam int COMB_W  = DATA_W + 2;    // (plus diff) - (minus diff)
   localparam int PROD_W  = HALF_W + 1 + COMB_W;   // 17 x 34 signed product
   localparam int SUM_W   = PROD_W + 3;    // three products plus centre
   localparam int RES_W   = SUM_W + 1;     // final sum before clamp
   localparam int MASK_W  = 6;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_TDATA_W = 232;       // 7 x 32 + 6, padded to bytes
   localparam int RSP_TDATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_Z = 2'd2;

   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

   // round half up on the fractional product sum
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);

   // load strobes for the two pipeline stages inside an axis lane
   typedef struct packed {
      logic ld_diff;
      logic ld_prod;
   } axis_ctl_type;

endpackage

[rtl/mdsu_axis.sv]
// One axis lane: masked differences, then split coefficient products.
// Depends on mdsu_pkg.
module mdsu_axis
   import mdsu_pkg::*;
(
   input  logic                     clock,
   input  axis_ctl_type             ctl,
   input  logic signed [DATA_W-1:0] center,
   input  logic signed [DATA_W-1:0] minus_value,
   input  logic signed [DATA_W-1:0] plus_value,
   input  logic                     minus_usable,
   input  logic                     plus_usable,
   input  logic [DATA_W-1:0]        coeff,
   output logic signed [PROD_W-1:0] prod_hi,   // coeff[31:16] * comb
   output logic signed [PROD_W-1:0] prod_lo    // coeff[15:0]  * comb
);

   logic signed [DIFF_W-1:0] diff_m;
   logic signed [DIFF_W-1:0] diff_p;
   logic signed [COMB_W-1:0] comb_in;
   logic signed [COMB_W-1:0] comb_ff;
   logic signed [HALF_W:0]   coeff_hi;
   logic signed [HALF_W:0]   coeff_lo;
   logic signed [PROD_W-1:0] prod_hi_in;
   logic signed [PROD_W-1:0] prod_lo_in;
   logic signed [PROD_W-1:0] prod_hi_ff;
   logic signed [PROD_W-1:0] prod_lo_ff;

   // unusable neighbour contributes a zero difference
   always_comb begin
      diff_m  = minus_usable ? (DIFF_W'(center) - DIFF_W'(minus_value)) : '0;
      diff_p  = plus_usable  ? (DIFF_W'(plus_value) - DIFF_W'(center))  : '0;
      comb_in = COMB_W'(diff_p) - COMB_W'(diff_m);
   end

   always_comb begin
      coeff_hi   = $signed({1'b0, coeff[DATA_W-1:HALF_W]});
      coeff_lo   = $signed({1'b0, coeff[HALF_W-1:0]});
      prod_hi_in = PROD_W'(coeff_hi) * PROD_W'(comb_ff);
      prod_lo_in = PROD_W'(coeff_lo) * PROD_W'(comb_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_diff) begin
         comb_ff <= comb_in;
      end
      if (ctl.ld_prod) begin
         prod_hi_ff <= prod_hi_in;
         prod_lo_ff <= prod_lo_in;
      end
   end

   assign prod_hi = prod_hi_ff;
   assign prod_lo = prod_lo_ff;

endmodule

[rtl/masked_diffusion_stencil_update.sv]
// Top level of the masked seven-point diffusion update (forward Euler, Q16.16).
// Depends on mdsu_pkg and mdsu_axis.
//
// Takes one grid cell per req transfer (centre, six axis neighbours, a
// neighbour usability mask and a fluid flag for the centre) and returns the
// updated centre value per rsp transfer. For a fluid centre the result is
// centre + cx*(dx+ - dx-) + cy*(dy+ - dy-) + cz*(dz+ - dz-), where a
// difference against an unusable neighbour is zero; the coefficient
// products are kept exact, summed, rounded once to Q16.16 (half up) and the
// sum is clamped to the signed 32-bit range, with rsp_tuser set on a clamp.
// A non-fluid centre comes back unchanged with rsp_tuser low.
// Throughput is one cell per clock while rsp is not stalled; a result passes
// through five register stages (input, masked differences, coefficient
// products, sums, round/clamp) before rsp_tvalid rises, the first of which
// loads on the transfer edge itself. Each stage holds its item only while the
// stage behind it is full and stalled, so bubbles close up and the input
// keeps taking items while a result waits on rsp.
// Coefficients are written through csr_* and are only to be changed while
// the pipeline is empty; writes to an index beyond coeff_z are ignored.
module masked_diffusion_stencil_update
   import mdsu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   // cell input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] center_value, [63:32] x_minus_value, [95:64] x_plus_value,
   // [127:96] y_minus_value, [159:128] y_plus_value, [191:160] z_minus_value,
   // [223:192] z_plus_value, [229:224] neighbour_usable, [231:230] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,   // [0] center_is_fluid

   // updated value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] new_value
   output logic                   rsp_tuser,   // [0] saturated

   // coefficient registers
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   // ---------------------------------------------------------------
   // Coefficient registers
   // ---------------------------------------------------------------
   logic [DATA_W-1:0] coeff_x_ff;
   logic [DATA_W-1:0] coeff_y_ff;
   logic [DATA_W-1:0] coeff_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_x_ff <= '0;
         coeff_y_ff <= '0;
         coeff_z_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEFF_X: coeff_x_ff <= csr_wdata;
            CSR_COEFF_Y: coeff_y_ff <= csr_wdata;
            CSR_COEFF_Z: coeff_z_ff <= csr_wdata;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline flow control: a stage loads when it is empty or when the
   // stage behind it moves on in the same clock.
   // ---------------------------------------------------------------
   logic v0_ff, v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic v0_in, v1_in, v2_in, v3_in, rsp_valid_in;
   logic rdy0, rdy1, rdy2, rdy3, rdy4;
   logic ld0, ld1, ld2, ld3, ld4;
   axis_ctl_type axis_ctl;

   always_comb begin
      rdy4 = !rsp_valid_ff || rsp_tready;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
      rdy0 = !v0_ff || rdy1;

      ld0 = rdy0 && req_tvalid;
      ld1 = rdy1 && v0_ff;
      ld2 = rdy2 && v1_ff;
      ld3 = rdy3 && v2_ff;
      ld4 = rdy4 && v3_ff;

      v0_in        = rdy0 ? req_tvalid : v0_ff;
      v1_in        = rdy1 ? v0_ff      : v1_ff;
      v2_in        = rdy2 ? v1_ff      : v2_ff;
      v3_in        = rdy3 ? v2_ff      : v3_ff;
      rsp_valid_in = rdy4 ? v3_ff      : rsp_valid_ff;

      axis_ctl.ld_diff = ld1;
      axis_ctl.ld_prod = ld2;
   end

   assign req_tready = rdy0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v0_ff        <= v0_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 0: input register
   // ---------------------------------------------------------------
   logic signed [DATA_W-1:0] c0_ff;
   logic signed [DATA_W-1:0] xm0_ff, xp0_ff, ym0_ff, yp0_ff, zm0_ff, zp0_ff;
   logic [MASK_W-1:0]        mask0_ff;
   logic                     fl0_ff;

   always_ff @(posedge clock) begin
      if (ld0) begin
         c0_ff    <= $signed(req_tdata[31:0]);
         xm0_ff   <= $signed(req_tdata[63:32]);
         xp0_ff   <= $signed(req_tdata[95:64]);
         ym0_ff   <= $signed(req_tdata[127:96]);
         yp0_ff   <= $signed(req_tdata[159:128]);
         zm0_ff   <= $signed(req_tdata[191:160]);
         zp0_ff   <= $signed(req_tdata[223:192]);
         mask0_ff <= req_tdata[229:224];
         fl0_ff   <= req_tuser;
      end
   end

   // ---------------------------------------------------------------
   // Stages 1 and 2: per-axis differences and products
   // ---------------------------------------------------------------
   logic signed [PROD_W-1:0] ph_x, pl_x, ph_y, pl_y, ph_z, pl_z;

   mdsu_axis u_axis_x (
      .clock        (clock),
      .ctl          (axis_ctl),
      .center       (c0_ff),
      .minus_value  (xm0_ff),
      .plus_value   (xp0_ff),
      .minus_usable (mask0_ff[0]),
      .plus_usable  (mask0_ff[1]),
      .coeff        (coeff_x_ff),
      .prod_hi      (ph_x),
      .prod_lo      (pl_x)
   );

   mdsu_axis u_axis_y (
      .clock        (clock),
      .ctl          (axis_ctl),
      .center       (c0_ff),
      .minus_value  (ym0_ff),
      .plus_value   (yp0_ff),
      .minus_usable (mask0_ff[2]),
      .plus_usable  (mask0_ff[3]),
      .coeff        (coeff_y_ff),
      .prod_hi      (ph_y),
      .prod_lo      (pl_y)
   );

   mdsu_axis u_axis_z (
      .clock        (clock),
      .ctl          (axis_ctl),
      .center       (c0_ff),
      .minus_value  (zm0_ff),
      .plus_value   (zp0_ff),
      .minus_usable (mask0_ff[4]),
      .plus_usable  (mask0_ff[5]),
      .coeff        (coeff_z_ff),
      .prod_hi      (ph_z),
      .prod_lo      (pl_z)
   );

   // centre and fluid flag ride alongside the lanes
   logic signed [DATA_W-1:0] c1_ff, c2_ff;
   logic                     fl1_ff, fl2_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         c1_ff  <= c0_ff;
         fl1_ff <= fl0_ff;
      end
      if (ld2) begin
         c2_ff  <= c1_ff;
         fl2_ff <= fl1_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: integer-weight sum (with centre) and fractional-weight sum
   // (with the rounding half). Total = hi*2^16 + lo, so the rounded result
   // is hi + floor(lo / 2^16).
   // ---------------------------------------------------------------
   logic signed [SUM_W-1:0]  hi3_in, lo3_in, hi3_ff, lo3_ff;
   logic signed [DATA_W-1:0] c3_ff;
   logic                     fl3_ff;

   always_comb begin
      hi3_in = SUM_W'(ph_x) + SUM_W'(ph_y) + SUM_W'(ph_z) + SUM_W'(c2_ff);
      lo3_in = SUM_W'(pl_x) + SUM_W'(pl_y) + SUM_W'(pl_z) + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         hi3_ff <= hi3_in;
         lo3_ff <= lo3_in;
         c3_ff  <= c2_ff;
         fl3_ff <= fl2_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: round, clamp, select pass-through
   // ---------------------------------------------------------------
   logic signed [RES_W-1:0]  res4;
   logic                     ovf_pos, ovf_neg;
   logic signed [DATA_W-1:0] new_value_in;
   logic                     sat_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff;
   logic                     rsp_sat_ff;

   always_comb begin
      res4    = RES_W'(hi3_ff) + RES_W'(lo3_ff >>> FRAC_W);
      ovf_pos = !res4[RES_W-1] && (res4[RES_W-2:DATA_W-1] != '0);
      ovf_neg =  res4[RES_W-1] && (res4[RES_W-2:DATA_W-1] != '1);
      priority if (!fl3_ff) begin
         new_value_in = c3_ff;
         sat_in       = 1'b0;
      end else if (ovf_pos) begin
         new_value_in = VALUE_MAX;
         sat_in       = 1'b1;
      end else if (ovf_neg) begin
         new_value_in = VALUE_MIN;
         sat_in       = 1'b1;
      end else begin
         new_value_in = res4[DATA_W-1:0];
         sat_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld4) begin
         rsp_data_ff <= new_value_in;
         rsp_sat_ff  <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // a clamped result sits exactly on a rail
   a_sat_on_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata == VALUE_MAX || rsp_tdata == VALUE_MIN))
      else $error("saturated result not on a rail");

   // a pass-through cell never reports saturation
   a_passthru_nosat: assert property (@(posedge clock) disable iff (reset)
      (ld4 && !fl3_ff) |=> (rsp_tvalid && !rsp_tuser && rsp_tdata == $past(c3_ff)))
      else $error("non-fluid cell altered");

   // an accepted cell lands in the input stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v0_ff)
      else $error("accepted cell lost at input stage");

   // with the output stalled, stage 3 keeps its item
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && v3_ff) |=> (v3_ff && $stable(hi3_ff)))
      else $error("stage 3 item lost during output stall");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !v0_ff && !v3_ff))
      else $error("pipeline not empty after reset");

endmodule
